// ===== hw/rtl/hks_pkg.sv =====
// Shared constants, types and a helper function of the HID key set report builder.
package hks_pkg;

  // Key map geometry.
  localparam int KEY_SPACE   = 256;
  localparam int WORD_W      = 16;
  localparam int MAP_WORDS   = KEY_SPACE / WORD_W;
  localparam int ADDR_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int HELD_CNT_W  = $clog2(KEY_SPACE + 1);

  // Report geometry.
  localparam int REPORT_SLOTS = 6;
  localparam int SLOT_FIELDS  = 6;
  localparam int SLOT_CNT     = (REPORT_SLOTS < SLOT_FIELDS) ? REPORT_SLOTS : SLOT_FIELDS;
  localparam int SLOT_IDX_W   = (SLOT_CNT > 1) ? $clog2(SLOT_CNT) : 1;
  localparam int SLOT_CNT_W   = $clog2(SLOT_CNT + 1);

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int CODE_W  = 16;
  localparam int KEY_W   = 8;
  localparam int MOD_W   = 8;
  localparam int USAGE_W = 16;

  localparam logic KIND_KEYBOARD = 1'b0;
  localparam logic KIND_CONSUMER = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_PRESS_KEY    = 3'd0,
    CMD_RELEASE_KEY  = 3'd1,
    CMD_RELEASE_ALL  = 3'd2,
    CMD_PRESS_MOD    = 3'd3,
    CMD_RELEASE_MOD  = 3'd4,
    CMD_SET_MOD      = 3'd5,
    CMD_PRESS_CONS   = 3'd6,
    CMD_RELEASE_CONS = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_SCAN_REQ,
    S_SCAN_PICK,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic              re;
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
  } ram_req_t;

  typedef struct packed {
    logic                              return_flag;
    logic                              report_sent;
    logic                              report_kind;
    logic [MOD_W-1:0]                  modifier_out;
    logic [SLOT_FIELDS-1:0][KEY_W-1:0] slot;
    logic [USAGE_W-1:0]                consumer_usage;
  } res_t;

  // Index of the lowest set bit of a map word; zero when the word is empty.
  function automatic logic [BIT_W-1:0] lowest_set(logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/hks_if.sv =====
// Command and report channel interfaces of the HID key set report builder.
interface hks_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [hks_pkg::CMD_W-1:0]  command;
  logic [hks_pkg::CODE_W-1:0] code;

  modport source (output valid, output command, output code, input ready);
  modport sink (input valid, input command, input code, output ready);
endinterface

interface hks_rpt_if;
  logic                        valid;
  logic                        ready;
  logic                        return_flag;
  logic                        report_sent;
  logic                        report_kind;
  logic [hks_pkg::MOD_W-1:0]   modifier_out;
  logic [hks_pkg::KEY_W-1:0]   slot0;
  logic [hks_pkg::KEY_W-1:0]   slot1;
  logic [hks_pkg::KEY_W-1:0]   slot2;
  logic [hks_pkg::KEY_W-1:0]   slot3;
  logic [hks_pkg::KEY_W-1:0]   slot4;
  logic [hks_pkg::KEY_W-1:0]   slot5;
  logic [hks_pkg::USAGE_W-1:0] consumer_usage;

  modport source (output valid, output return_flag, output report_sent, output report_kind,
                  output modifier_out, output slot0, output slot1, output slot2,
                  output slot3, output slot4, output slot5, output consumer_usage,
                  input ready);
  modport sink (input valid, input return_flag, input report_sent, input report_kind,
                input modifier_out, input slot0, input slot1, input slot2,
                input slot3, input slot4, input slot5, input consumer_usage,
                output ready);
endinterface

// ===== hw/rtl/hid_key_set_report_builder_top.sv =====
// Top level of the HID key set report builder: sequencer, key map RAM and output register.
//
//   Channel  Dir  Words carried
//   cmd_i    in   command (3 bits), code (16 bits)
//   rpt_o    out  return_flag, report_sent, report_kind, modifier_out, slot0..slot5,
//                 consumer_usage
//
// One command word at a time. Modifier set, release all and consumer commands go
// straight to the result; a key press or release first reads its map row and
// rewrites it if the key changes state. A key or modifier press or release that
// sends a report then sweeps the 16-row key map RAM row by row, taking the held
// codes of each row lowest first; the sweep stops once six codes are found.
// The key map clears at once on reset through per-row valid bits.
// The output register lets the next command in while a result word waits on rpt_o.
module hid_key_set_report_builder_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  hks_cmd_if.sink   cmd_i,
  hks_rpt_if.source rpt_o
);
  import hks_pkg::*;

  ram_req_t          ram_req;
  logic [WORD_W-1:0] ram_rdata;
  logic              res_valid;
  logic              res_ready;
  res_t              res;

  hks_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_ready_o (cmd_i.ready),
    .command_i   (cmd_e'(cmd_i.command)),
    .code_i      (cmd_i.code),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  hks_ram #(
    .Width (WORD_W),
    .Depth (MAP_WORDS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .re_i    (ram_req.re),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  hks_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .rpt_o       (rpt_o)
  );

endmodule

// ===== hw/rtl/hks_ram.sv =====
// Generic single-port RAM with registered read data.
module hks_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  re_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                      wdata_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hks_core.sv =====
// Command sequencer: map read-modify-write, report sweep over the map RAM, modifier state.
module hks_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  hks_pkg::cmd_e               command_i,
  input  logic [hks_pkg::CODE_W-1:0]  code_i,
  output hks_pkg::ram_req_t           ram_req_o,
  input  logic [hks_pkg::WORD_W-1:0]  ram_rdata_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output hks_pkg::res_t               res_o
);
  import hks_pkg::*;

  state_e                state_q, state_d;
  cmd_e                  cmd_q, cmd_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [USAGE_W-1:0]    usage_q, usage_d;
  logic                  flag_q, flag_d;
  logic                  sent_q, sent_d;
  logic                  kind_q, kind_d;
  logic [MOD_W-1:0]      mod_q, mod_d;
  logic                  seen_q, seen_d;
  logic [HELD_CNT_W-1:0] cnt_q, cnt_d;
  logic [MAP_WORDS-1:0]  row_valid_q, row_valid_d;
  logic [ADDR_W-1:0]     scan_addr_q, scan_addr_d;
  logic [WORD_W-1:0]     work_q, work_d;
  logic                  first_q, first_d;
  logic [SLOT_CNT_W-1:0] slot_n_q, slot_n_d;
  logic [KEY_W-1:0]      slots_q [SLOT_CNT];
  logic                  slot_clr;
  logic                  slot_we;
  logic [KEY_W-1:0]      slot_val;

  logic                  accept;
  logic [KEY_W-1:0]      in_key;
  logic                  in_key_ok;
  logic [ADDR_W-1:0]     key_row;
  logic [BIT_W-1:0]      key_bit;
  logic [WORD_W-1:0]     key_mask;
  logic [WORD_W-1:0]     mod_word;
  logic                  hit;
  logic [WORD_W-1:0]     pick_word;
  logic [WORD_W-1:0]     rest_word;
  logic                  take;
  logic                  last_row;
  logic [KEY_W-1:0]      slot_view [SLOT_FIELDS];

  assign accept    = cmd_valid_i && cmd_ready_o;
  assign in_key    = code_i[KEY_W-1:0];
  assign in_key_ok = int'(in_key) < KEY_SPACE;
  assign key_row   = key_q[BIT_W +: ADDR_W];
  assign key_bit   = key_q[BIT_W-1:0];
  assign key_mask  = WORD_W'(1) << key_bit;
  assign mod_word  = row_valid_q[key_row] ? ram_rdata_i : '0;
  assign hit       = (mod_word & key_mask) != '0;
  assign last_row  = scan_addr_q == ADDR_W'(MAP_WORDS - 1);

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    usage_d     = usage_q;
    flag_d      = flag_q;
    sent_d      = sent_q;
    kind_d      = kind_q;
    mod_d       = mod_q;
    seen_d      = seen_q;
    cnt_d       = cnt_q;
    row_valid_d = row_valid_q;
    scan_addr_d = scan_addr_q;
    work_d      = work_q;
    first_d     = first_q;
    slot_n_d    = slot_n_q;
    slot_clr    = 1'b0;
    slot_we     = 1'b0;
    slot_val    = '0;
    ram_req_o   = '0;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    pick_word   = first_q ? (row_valid_q[scan_addr_q] ? ram_rdata_i : '0) : work_q;
    take        = (pick_word != '0) && (int'(slot_n_q) < SLOT_CNT);
    rest_word   = take ? (pick_word & (pick_word - WORD_W'(1))) : pick_word;

    unique case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (accept) begin
          cmd_d       = command_i;
          key_d       = in_key;
          usage_d     = '0;
          flag_d      = 1'b0;
          sent_d      = 1'b0;
          kind_d      = KIND_KEYBOARD;
          scan_addr_d = '0;
          slot_n_d    = '0;
          slot_clr    = 1'b1;
          state_d     = S_FINISH;
          unique case (command_i)
            CMD_PRESS_KEY, CMD_RELEASE_KEY: begin
              if (in_key_ok) begin
                // Fetch the map row now; it is modified in the next cycle.
                ram_req_o.re   = 1'b1;
                ram_req_o.addr = in_key[BIT_W +: ADDR_W];
                state_d        = S_MODIFY;
              end
            end
            CMD_RELEASE_ALL: begin
              if (cnt_q != '0) begin
                row_valid_d = '0;
                cnt_d       = '0;
                flag_d      = 1'b1;
                sent_d      = 1'b1;
              end
            end
            CMD_PRESS_MOD: begin
              mod_d   = mod_q | in_key;
              flag_d  = 1'b1;
              sent_d  = 1'b1;
              state_d = S_SCAN_REQ;
            end
            CMD_RELEASE_MOD: begin
              mod_d   = mod_q & ~in_key;
              flag_d  = 1'b1;
              sent_d  = 1'b1;
              state_d = S_SCAN_REQ;
            end
            CMD_SET_MOD: begin
              mod_d  = in_key;
              flag_d = 1'b1;
            end
            CMD_PRESS_CONS: begin
              sent_d  = 1'b1;
              kind_d  = KIND_CONSUMER;
              usage_d = code_i;
              seen_d  = 1'b1;
            end
            CMD_RELEASE_CONS: begin
              if (!seen_q) begin
                flag_d = 1'b1;
              end else begin
                sent_d = 1'b1;
                kind_d = KIND_CONSUMER;
              end
            end
          endcase
        end
      end
      S_MODIFY: begin
        state_d = S_FINISH;
        if ((cmd_q == CMD_PRESS_KEY) && !hit) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = key_row;
          ram_req_o.wdata = mod_word | key_mask;
          row_valid_d[key_row] = 1'b1;
          cnt_d   = cnt_q + HELD_CNT_W'(1);
          flag_d  = 1'b1;
          sent_d  = 1'b1;
          state_d = S_SCAN_REQ;
        end else if ((cmd_q == CMD_RELEASE_KEY) && hit) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = key_row;
          ram_req_o.wdata = mod_word & ~key_mask;
          row_valid_d[key_row] = 1'b1;
          cnt_d   = cnt_q - HELD_CNT_W'(1);
          flag_d  = 1'b1;
          sent_d  = 1'b1;
          state_d = S_SCAN_REQ;
        end
      end
      S_SCAN_REQ: begin
        ram_req_o.re   = 1'b1;
        ram_req_o.addr = scan_addr_q;
        first_d        = 1'b1;
        state_d        = S_SCAN_PICK;
      end
      S_SCAN_PICK: begin
        // One held code per cycle leaves the current row, lowest first.
        if (take) begin
          slot_we  = 1'b1;
          slot_val = KEY_W'({scan_addr_q, lowest_set(pick_word)});
          slot_n_d = slot_n_q + SLOT_CNT_W'(1);
        end
        if ((int'(slot_n_d) == SLOT_CNT) || ((rest_word == '0) && last_row)) begin
          state_d = S_FINISH;
        end else if (rest_word == '0) begin
          ram_req_o.re   = 1'b1;
          ram_req_o.addr = scan_addr_q + ADDR_W'(1);
          scan_addr_d    = scan_addr_q + ADDR_W'(1);
          first_d        = 1'b1;
        end else begin
          work_d  = rest_word;
          first_d = 1'b0;
        end
      end
      S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mod_q       <= '0;
      seen_q      <= 1'b0;
      cnt_q       <= '0;
      row_valid_q <= '0;
      slot_n_q    <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      mod_q       <= mod_d;
      seen_q      <= seen_d;
      cnt_q       <= cnt_d;
      row_valid_q <= row_valid_d;
      slot_n_q    <= slot_n_d;
      first_q     <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    key_q       <= key_d;
    usage_q     <= usage_d;
    flag_q      <= flag_d;
    sent_q      <= sent_d;
    kind_q      <= kind_d;
    scan_addr_q <= scan_addr_d;
    work_q      <= work_d;
    if (slot_clr) begin
      for (int i = 0; i < SLOT_CNT; i++) begin
        slots_q[i] <= '0;
      end
    end else if (slot_we) begin
      slots_q[slot_n_q[SLOT_IDX_W-1:0]] <= slot_val;
    end
  end

  for (genvar g = 0; g < SLOT_FIELDS; g++) begin : g_slot
    if (g < SLOT_CNT) begin : g_used
      assign slot_view[g] = slots_q[g];
    end else begin : g_pad
      assign slot_view[g] = '0;
    end
  end

  always_comb begin
    res_o                = '0;
    res_o.return_flag    = flag_q;
    res_o.report_sent    = sent_q;
    res_o.report_kind    = sent_q ? kind_q : KIND_KEYBOARD;
    if (sent_q && (kind_q == KIND_KEYBOARD)) begin
      res_o.modifier_out = mod_q;
      for (int i = 0; i < SLOT_FIELDS; i++) begin
        res_o.slot[i] = slot_view[i];
      end
    end
    if (sent_q && (kind_q == KIND_CONSUMER)) begin
      res_o.consumer_usage = usage_q;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != S_IDLE))
    else $error("command word accepted but sequencer stayed idle");

  a_write_only_in_modify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (state_q == S_MODIFY))
    else $error("map RAM written outside the modify step");

  a_slot_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(slot_n_q) <= SLOT_CNT)
    else $error("report slot count overran");

  a_release_all_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (command_i == CMD_RELEASE_ALL)) |=> (cnt_q == '0))
    else $error("held count not zero after release all");

endmodule

// ===== hw/rtl/hks_out_stage.sv =====
// Output register that holds one result word while the next command is taken.
module hks_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  output logic          res_ready_o,
  input  hks_pkg::res_t res_i,
  hks_rpt_if.source     rpt_o
);
  import hks_pkg::*;

  logic valid_q, valid_d;
  res_t data_q, data_d;
  logic load;

  assign res_ready_o = !valid_q || rpt_o.ready;
  assign load        = res_valid_i && res_ready_o;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (load) begin
      valid_d = 1'b1;
      data_d  = res_i;
    end else if (rpt_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign rpt_o.valid          = valid_q;
  assign rpt_o.return_flag    = data_q.return_flag;
  assign rpt_o.report_sent    = data_q.report_sent;
  assign rpt_o.report_kind    = data_q.report_kind;
  assign rpt_o.modifier_out   = data_q.modifier_out;
  assign rpt_o.slot0          = data_q.slot[0];
  assign rpt_o.slot1          = data_q.slot[1];
  assign rpt_o.slot2          = data_q.slot[2];
  assign rpt_o.slot3          = data_q.slot[3];
  assign rpt_o.slot4          = data_q.slot[4];
  assign rpt_o.slot5          = data_q.slot[5];
  assign rpt_o.consumer_usage = data_q.consumer_usage;

endmodule

// ===== tb/tb_hid_key_set_report_builder_top.sv =====
// Self-checking testbench for the HID key set report builder, with random flow control.
`timescale 1ns / 100ps

module tb_hid_key_set_report_builder_top;
  import hks_pkg::*;

  localparam int RANDOM_WORDS = 1600;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    cmd_e        cmd;
    logic [15:0] code;
    bit          fixed;
    res_t        want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  hks_cmd_if cmd_if ();
  hks_rpt_if rpt_if ();

  hid_key_set_report_builder_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rpt_o  (rpt_if)
  );

  // Predicted key board state.
  logic [KEY_SPACE-1:0] held_keys;
  logic [MOD_W-1:0]     mod_bits;
  logic                 consumer_used;

  res_t      owed_reports[$];
  stim_row_t stim_table[$];

  // A typed expectation travels with the word that is on the command channel.
  bit   word_fixed;
  res_t word_want;

  int mismatches;
  int words_in;
  int keyboard_reports;
  int consumer_reports;
  int quiet_results;
  int peak_held;
  int idle_cycles;
  int burst_left;

  logic hold_req;
  bit   hold_done;
  int   hold_left;
  int   stall_mode;
  int   phase_left;
  int   rx_cycle;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic res_t plain_res(logic flag, logic sent, logic kind, logic [15:0] usage);
    res_t r;
    r = '0;
    r.return_flag    = flag;
    r.report_sent    = sent;
    r.report_kind    = kind;
    r.consumer_usage = usage;
    return r;
  endfunction

  // Keyboard report from the predicted state: modifier byte and the lowest held codes.
  function automatic res_t keyboard_report();
    res_t r;
    int   n;
    r = '0;
    n = 0;
    r.return_flag  = 1'b1;
    r.report_sent  = 1'b1;
    r.report_kind  = KIND_KEYBOARD;
    r.modifier_out = mod_bits;
    for (int k = 0; k < KEY_SPACE; k++) begin
      if (held_keys[k] && n < SLOT_CNT) begin
        r.slot[n] = k[KEY_W-1:0];
        n++;
      end
    end
    return r;
  endfunction

  function automatic res_t next_report(cmd_e cmd, logic [15:0] code);
    res_t       r;
    logic [7:0] key;
    r   = '0;
    key = code[7:0];
    case (cmd)
      CMD_PRESS_KEY: begin
        if (!held_keys[key]) begin
          held_keys[key] = 1'b1;
          r = keyboard_report();
        end
      end
      CMD_RELEASE_KEY: begin
        if (held_keys[key]) begin
          held_keys[key] = 1'b0;
          r = keyboard_report();
        end
      end
      CMD_RELEASE_ALL: begin
        if (held_keys != '0) begin
          held_keys = '0;
          r = keyboard_report();
        end
      end
      CMD_PRESS_MOD: begin
        mod_bits = mod_bits | key;
        r = keyboard_report();
      end
      CMD_RELEASE_MOD: begin
        mod_bits = mod_bits & ~key;
        r = keyboard_report();
      end
      CMD_SET_MOD: begin
        mod_bits = key;
        r.return_flag = 1'b1;
      end
      CMD_PRESS_CONS: begin
        consumer_used = 1'b1;
        r = plain_res(1'b0, 1'b1, KIND_CONSUMER, code);
      end
      default: begin
        // Releasing a consumer usage that was never pressed sends nothing.
        if (!consumer_used) begin
          r.return_flag = 1'b1;
        end else begin
          r = plain_res(1'b0, 1'b1, KIND_CONSUMER, 16'h0000);
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
    end
  endtask

  task automatic add_row(cmd_e cmd, logic [15:0] code, bit fixed, res_t want);
    stim_row_t row;
    row.cmd   = cmd;
    row.code  = code;
    row.fixed = fixed;
    row.want  = want;
    stim_table.push_back(row);
  endtask

  // Offers one command word, waits until it is taken, then pauses after each random burst.
  task automatic offer_word(cmd_e cmd, logic [15:0] code, bit fixed, res_t want);
    cmd_if.valid   <= 1'b1;
    cmd_if.command <= cmd;
    cmd_if.code    <= code;
    word_fixed     <= fixed;
    word_want      <= want;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (burst_left == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end else begin
      burst_left--;
    end
  endtask

  // Prediction and checking at the handshakes.
  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    res_t pred;
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        pred = next_report(cmd_e'(cmd_if.command), cmd_if.code);
        owed_reports.push_back(word_fixed ? word_want : pred);
        words_in++;
        if ($countones(held_keys) > peak_held) begin
          peak_held = $countones(held_keys);
        end
      end
      if (rpt_if.valid && rpt_if.ready) begin
        if (owed_reports.size() == 0) begin
          mismatches++;
          $display("%0t: report word with none expected", $time);
        end else begin
          want = owed_reports.pop_front();
          got.return_flag    = rpt_if.return_flag;
          got.report_sent    = rpt_if.report_sent;
          got.report_kind    = rpt_if.report_kind;
          got.modifier_out   = rpt_if.modifier_out;
          got.slot           = {rpt_if.slot5, rpt_if.slot4, rpt_if.slot3,
                                rpt_if.slot2, rpt_if.slot1, rpt_if.slot0};
          got.consumer_usage = rpt_if.consumer_usage;
          check_field("return_flag", 16'(want.return_flag), 16'(got.return_flag));
          check_field("report_sent", 16'(want.report_sent), 16'(got.report_sent));
          check_field("report_kind", 16'(want.report_kind), 16'(got.report_kind));
          check_field("modifier_out", 16'(want.modifier_out), 16'(got.modifier_out));
          for (int s = 0; s < SLOT_FIELDS; s++) begin
            check_field($sformatf("slot%0d", s), 16'(want.slot[s]), 16'(got.slot[s]));
          end
          check_field("consumer_usage", want.consumer_usage, got.consumer_usage);
          if (!want.report_sent) begin
            quiet_results++;
          end else if (want.report_kind == KIND_CONSUMER) begin
            consumer_reports++;
          end else begin
            keyboard_reports++;
          end
        end
      end
    end
  end

  // The watchdog restarts its count on every handshake on either channel.
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (rpt_if.valid && rpt_if.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("hid_key_set_report_builder_top: mismatch");
      $finish;
    end
  end

  // Report sink: random stall patterns that change from phase to phase, plus one long hold-off.
  initial begin
    rpt_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rx_cycle++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (phase_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 96);
      end
      phase_left--;
      if (hold_left > 0) begin
        hold_left--;
        rpt_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: rpt_if.ready <= 1'b1;
          1: rpt_if.ready <= ($urandom_range(0, 9) < 7);
          2: rpt_if.ready <= ($urandom_range(0, 9) < 3);
          default: rpt_if.ready <= rx_cycle[2];
        endcase
      end
    end
  end

  initial begin
    int          pick;
    cmd_e        cmd;
    logic [7:0]  key;
    logic [15:0] code;

    held_keys      = '0;
    mod_bits       = '0;
    consumer_used  = 1'b0;
    rst_ni         = 1'b0;
    clk_i          = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.command = CMD_PRESS_KEY;
    cmd_if.code    = '0;
    word_fixed     = 1'b0;
    word_want      = '0;
    hold_req       = 1'b0;
    burst_left     = $urandom_range(1, 40);

    // Edge cases first: empty set, unseen consumer release, repeats, slot limit, modifiers.
    add_row(CMD_RELEASE_ALL,  16'h0000, 1'b1, plain_res(1'b0, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_RELEASE_CONS, 16'hFFFF, 1'b1, plain_res(1'b1, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_RELEASE_KEY,  16'h0004, 1'b1, plain_res(1'b0, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_PRESS_KEY,    16'hFF00, 1'b1, plain_res(1'b1, 1'b1, 1'b0, 16'h0000));
    add_row(CMD_PRESS_KEY,    16'h00FF, 1'b0, '0);
    add_row(CMD_PRESS_KEY,    16'hA5FF, 1'b1, plain_res(1'b0, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_PRESS_KEY,    16'h8004, 1'b0, '0);
    add_row(CMD_PRESS_KEY,    16'h0105, 1'b0, '0);
    add_row(CMD_PRESS_KEY,    16'h7F06, 1'b0, '0);
    add_row(CMD_PRESS_KEY,    16'h0007, 1'b0, '0);
    add_row(CMD_PRESS_KEY,    16'h5508, 1'b0, '0);
    add_row(CMD_PRESS_MOD,    16'hFF80, 1'b0, '0);
    add_row(CMD_SET_MOD,      16'h00FF, 1'b1, plain_res(1'b1, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_RELEASE_MOD,  16'h0F0F, 1'b0, '0);
    add_row(CMD_RELEASE_KEY,  16'h0000, 1'b0, '0);
    add_row(CMD_PRESS_CONS,   16'hFFFF, 1'b1, plain_res(1'b0, 1'b1, 1'b1, 16'hFFFF));
    add_row(CMD_PRESS_CONS,   16'h0000, 1'b1, plain_res(1'b0, 1'b1, 1'b1, 16'h0000));
    add_row(CMD_RELEASE_CONS, 16'h5A5A, 1'b1, plain_res(1'b0, 1'b1, 1'b1, 16'h0000));
    add_row(CMD_RELEASE_ALL,  16'h1234, 1'b0, '0);
    add_row(CMD_RELEASE_ALL,  16'h0000, 1'b1, plain_res(1'b0, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_SET_MOD,      16'h0000, 1'b1, plain_res(1'b1, 1'b0, 1'b0, 16'h0000));
    add_row(CMD_RELEASE_MOD,  16'hFFFF, 1'b1, plain_res(1'b1, 1'b1, 1'b0, 16'h0000));
    add_row(CMD_RELEASE_KEY,  16'h00FF, 1'b1, plain_res(1'b0, 1'b0, 1'b0, 16'h0000));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      offer_word(stim_table[i].cmd, stim_table[i].code, stim_table[i].fixed,
                 stim_table[i].want);
    end

    // Mostly presses and releases on a small pool of codes, so the set often
    // grows past the slot count and releases usually hit held keys.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) begin
        hold_req <= 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        key = 8'($urandom_range(0, 15));
      end else if (pick < 8) begin
        key = 8'($urandom_range(240, 255));
      end else begin
        key = 8'($urandom_range(0, 255));
      end
      code = {8'($urandom_range(0, 255)), key};
      pick = $urandom_range(0, 99);
      if (pick < 36) begin
        cmd = CMD_PRESS_KEY;
      end else if (pick < 66) begin
        cmd = CMD_RELEASE_KEY;
      end else if (pick < 70) begin
        cmd = CMD_RELEASE_ALL;
      end else if (pick < 77) begin
        cmd = CMD_PRESS_MOD;
      end else if (pick < 83) begin
        cmd = CMD_RELEASE_MOD;
      end else if (pick < 88) begin
        cmd = CMD_SET_MOD;
      end else if (pick < 95) begin
        cmd = CMD_PRESS_CONS;
      end else begin
        cmd = CMD_RELEASE_CONS;
      end
      if (cmd inside {CMD_PRESS_MOD, CMD_RELEASE_MOD, CMD_SET_MOD, CMD_PRESS_CONS,
                      CMD_RELEASE_CONS}) begin
        code = 16'($urandom_range(0, 65535));
      end
      offer_word(cmd, code, 1'b0, '0);
    end

    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (owed_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d command words: %0d keyboard reports, %0d consumer reports,",
             words_in, keyboard_reports, consumer_reports);
    $display("%0d results without a report, up to %0d keys held at once.",
             quiet_results, peak_held);
    if (mismatches == 0) begin
      $display("hid_key_set_report_builder_top: match");
    end else begin
      $display("hid_key_set_report_builder_top: mismatch");
    end
    $finish;
  end

endmodule

// ===== hid_key_set_report_builder_top.f =====
hw/rtl/hks_pkg.sv
hw/rtl/hks_if.sv
hw/rtl/hks_ram.sv
hw/rtl/hks_core.sv
hw/rtl/hks_out_stage.sv
hw/rtl/hid_key_set_report_builder_top.sv
tb/tb_hid_key_set_report_builder_top.sv
